### sv/hdlc_pkg.sv
// Shared types, constants and the CRC fold function for the HDLC-style framer.
// No dependencies; imported by every module of the block.
package hdlc_pkg;

    // Line codes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLIP  = 8'h20;
    localparam logic [7:0] ERR_BYTE  = 8'h00;

    // CRC seed and reset polynomial
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] POLY_INIT = 16'h8408;

    // Input item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result sequencing: at most six line bytes per item
    localparam int STEP_W         = 3;
    localparam logic [STEP_W-1:0] START_BODY = 3'd3;
    localparam logic [STEP_W-1:0] DATA_BODY  = 3'd1;
    localparam logic [STEP_W-1:0] ESC_BODY   = 3'd2;
    localparam logic [STEP_W-1:0] ERR_BODY   = 3'd1;
    localparam logic [STEP_W-1:0] TAIL_LEN   = 3'd3;

    // Tail byte positions
    localparam logic [STEP_W-1:0] TAIL_LO   = 3'd0;
    localparam logic [STEP_W-1:0] TAIL_HI   = 3'd1;
    localparam logic [STEP_W-1:0] TAIL_FLAG = 3'd2;

    // Classified request kinds handed from front to back
    typedef enum logic [1:0] {
        KIND_START,
        KIND_DATA,
        KIND_DATA_ESC,
        KIND_ERR
    } hdlc_kind_t;

    // One queued request
    typedef struct packed {
        hdlc_kind_t  kind;
        logic [7:0]  byte0;     // tag on start, payload byte on data
        logic [7:0]  byte1;     // length on start
        logic [15:0] tail_crc;  // running CRC to close the frame with
        logic        has_tail;
    } hdlc_cmd_t;

    localparam int CMD_W = $bits(hdlc_cmd_t);

    // Fold one byte into a reflected CRC-16, LSB first
    function automatic logic [15:0] crc_fold(
        input logic [15:0] crc_in,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] crc;
        crc = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0] ^ data[k])
                crc = (crc >> 1) ^ poly;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

### sv/hdlc_front.sv
// Front end: accepts input items, keeps CRC / frame state, classifies requests.
// Depends on hdlc_pkg; feeds hdlc_queue.
module hdlc_front (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         crc_poly,
    // input items
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                func,
    input  logic [7:0]          tag,
    input  logic [7:0]          length,
    input  logic [7:0]          data_byte,
    // towards the queue
    input  logic                q_full,
    output logic                push,
    output hdlc_pkg::hdlc_cmd_t cmd
);
    import hdlc_pkg::*;

    logic [15:0] poly_reg;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic        open_reg,       open_next;
    logic        pend_reg,       pend_next;
    logic [7:0]  pend_len_reg,   pend_len_next;
    logic        accept;
    logic [15:0] crc_data;
    logic [7:0]  left_dec;

    // Length byte is folded in the cycle after a start; input held off then
    assign item_stall = q_full | pend_reg;
    assign accept     = item_valid & ~item_stall;
    assign push       = accept;
    assign cfg_ready  = 1'b1;

    assign crc_data = crc_fold(crc_reg, data_byte, poly_reg);
    assign left_dec = bytes_left_reg - 8'd1;

    // Next state and request classification
    always_comb
    begin
        crc_next        = crc_reg;
        bytes_left_next = bytes_left_reg;
        open_next       = open_reg;
        pend_next       = 1'b0;
        pend_len_next   = pend_len_reg;
        cmd.kind        = KIND_ERR;
        cmd.byte0       = data_byte;
        cmd.byte1       = length;
        cmd.tail_crc    = crc_data;
        cmd.has_tail    = 1'b0;

        if (pend_reg)
            crc_next = crc_fold(crc_reg, pend_len_reg, poly_reg);

        if (accept)
        begin
            if (func == FUNC_START)
            begin
                cmd.kind  = KIND_START;
                cmd.byte0 = tag;
                if (length == 8'd0)
                begin
                    crc_next        = CRC_INIT;
                    bytes_left_next = 8'd0;
                    open_next       = 1'b0;
                    cmd.tail_crc    = CRC_INIT;
                    cmd.has_tail    = 1'b1;
                end
                else
                begin
                    crc_next        = crc_fold(CRC_INIT, tag, poly_reg);
                    bytes_left_next = length;
                    open_next       = 1'b1;
                    pend_next       = 1'b1;
                    pend_len_next   = length;
                end
            end
            else if (!open_reg)
            begin
                cmd.kind = KIND_ERR;
            end
            else
            begin
                crc_next        = crc_data;
                bytes_left_next = left_dec;
                if (data_byte == FLAG_BYTE || data_byte == ESC_BYTE)
                    cmd.kind = KIND_DATA_ESC;
                else
                    cmd.kind = KIND_DATA;
                if (left_dec == 8'd0)
                begin
                    open_next    = 1'b0;
                    cmd.has_tail = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg       <= POLY_INIT;
            crc_reg        <= CRC_INIT;
            bytes_left_reg <= 8'd0;
            open_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            pend_len_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                poly_reg <= crc_poly;
            crc_reg        <= crc_next;
            bytes_left_reg <= bytes_left_next;
            open_reg       <= open_next;
            pend_reg       <= pend_next;
            pend_len_reg   <= pend_len_next;
        end
    end

endmodule

### sv/hdlc_queue.sv
// Short request queue between front and back of the framer.
// Depends on hdlc_pkg for the request type.
module hdlc_queue #(
    parameter int DEPTH = hdlc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hdlc_pkg::hdlc_cmd_t wr_cmd,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output hdlc_pkg::hdlc_cmd_t rd_cmd
);
    import hdlc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hdlc_cmd_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/hdlc_back.sv
// Back end: expands queued requests into line bytes, one per cycle while line_stall does not hold the output.
// Depends on hdlc_pkg; drains hdlc_queue into the output register.
module hdlc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  hdlc_pkg::hdlc_cmd_t head,
    output logic                pop,
    output logic                line_valid,
    input  logic                line_stall,
    output logic [7:0]          out_byte,
    output logic                last_of_run,
    output logic                frame_end,
    output logic                status
);
    import hdlc_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] body_len, total_len, tail_idx;
    logic              valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg, end_reg, status_reg;
    logic              load, is_last;
    logic [7:0]        byte_sel;
    logic              end_sel;
    logic [15:0]       inv_crc;

    assign line_valid  = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign frame_end   = end_reg;
    assign status      = status_reg;

    assign load      = q_valid & (~valid_reg | ~line_stall);
    assign total_len = body_len + (head.has_tail ? TAIL_LEN : '0);
    assign is_last   = (step_reg == total_len - 1'b1);
    assign pop       = load & is_last;
    assign tail_idx  = step_reg - body_len;
    assign inv_crc   = ~head.tail_crc;

    // Body length per request kind
    always_comb
    begin
        unique case (head.kind)
            KIND_START:    body_len = START_BODY;
            KIND_DATA:     body_len = DATA_BODY;
            KIND_DATA_ESC: body_len = ESC_BODY;
            KIND_ERR:      body_len = ERR_BODY;
            default:       body_len = ERR_BODY;
        endcase
    end

    // Byte at the current step
    always_comb
    begin
        byte_sel = ERR_BYTE;
        end_sel  = 1'b0;
        if (step_reg >= body_len)
        begin
            case (tail_idx)
                TAIL_LO:   byte_sel = inv_crc[7:0];
                TAIL_HI:   byte_sel = inv_crc[15:8];
                default:
                begin
                    byte_sel = FLAG_BYTE;
                    end_sel  = 1'b1;
                end
            endcase
        end
        else
        begin
            unique case (head.kind)
                KIND_START:
                begin
                    if (step_reg == 3'd0)
                        byte_sel = FLAG_BYTE;
                    else if (step_reg == 3'd1)
                        byte_sel = head.byte0;
                    else
                        byte_sel = head.byte1;
                end
                KIND_DATA:     byte_sel = head.byte0;
                KIND_DATA_ESC: byte_sel = (step_reg == 3'd0) ? ESC_BYTE
                                                             : (head.byte0 ^ ESC_FLIP);
                KIND_ERR:      byte_sel = ERR_BYTE;
                default:       byte_sel = ERR_BYTE;
            endcase
        end
    end

    // Step counter within the head request
    always_comb
    begin
        step_next = step_reg;
        if (load)
            step_next = is_last ? '0 : step_reg + 1'b1;
    end

    // Output register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
                valid_reg <= 1'b1;
            else if (!line_stall)
                valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_sel;
            last_reg   <= is_last;
            end_reg    <= end_sel;
            status_reg <= (head.kind == KIND_ERR);
        end
    end

endmodule

### sv/hdlc_style_crc16_framer.sv
// HDLC-style byte-stuffing framer with reflected CRC-16: top level.
// Throughput: one line byte per cycle from the output sequencer, held by line_stall;
// one item per cycle while the queue is not full, with one held-off cycle after each
// non-empty start while the length byte is folded.
// Reset: frame closed, CRC 0xFFFF, polynomial 0x8408, queue and output emptied.
module hdlc_style_crc16_framer #(
    parameter int QUEUE_DEPTH = hdlc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] crc_poly,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        func,
    input  logic [7:0]  tag,
    input  logic [7:0]  length,
    input  logic [7:0]  data_byte,
    output logic        line_valid,
    input  logic        line_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        frame_end,
    output logic        status
);
    import hdlc_pkg::*;

    hdlc_cmd_t wr_cmd, rd_cmd;
    logic      push, pop, q_full, q_valid;

    hdlc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .crc_poly   (crc_poly),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .tag        (tag),
        .length     (length),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .cmd        (wr_cmd)
    );

    hdlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (wr_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .rd_cmd    (rd_cmd)
    );

    hdlc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head        (rd_cmd),
        .pop         (pop),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .status      (status)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for hdlc_style_crc16_framer: byte stuffing, CRC-16 tail, orphan bytes.
// Depends on hdlc_pkg (line codes, CRC seed, function codes) and the framer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlc_pkg::*;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;
    localparam int   PHASE_ITEMS     = 48;

    // One input request and one line byte as the framer should emit it
    typedef struct packed {
        logic       func;
        logic [7:0] tag;
        logic [7:0] len;
        logic [7:0] data;
    } frame_req_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_out;
        logic       closing;
        logic       no_frame;
    } line_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] crc_poly = POLY_INIT;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        func = FUNC_START;
    logic [7:0]  tag = 8'h00;
    logic [7:0]  length = 8'h00;
    logic [7:0]  data_byte = 8'h00;
    logic        line_valid;
    logic        line_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        frame_end;
    logic        status;

    frame_req_t  pending_items[$];
    line_res_t   expected_bytes[$];
    frame_req_t  next_req;
    line_res_t   want;

    // Shadow of the framer state and its polynomial register
    logic [15:0] poly_shadow = POLY_INIT;
    logic [15:0] crc_shadow = CRC_INIT;
    logic [7:0]  left_shadow = 8'd0;
    logic        open_shadow = 1'b0;

    int mismatches = 0;
    int items_taken = 0;
    int bytes_checked = 0;
    int frames_closed = 0;
    int orphan_bytes = 0;
    int poly_writes = 0;
    int phase_items = 0;
    int burst_left = 1;
    int gap_left = 0;
    logic sender_gaps = 1'b1;
    logic [15:0] stall_tick = 16'd0;
    logic [7:0]  stall_pat = 8'h00;

    hdlc_style_crc16_framer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .crc_poly    (crc_poly),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .func        (func),
        .tag         (tag),
        .length      (length),
        .data_byte   (data_byte),
        .line_valid  (line_valid),
        .line_stall  (line_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .status      (status)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reflected CRC-16: XOR the byte into the low end, then eight shifts
    function automatic logic [15:0] crc16_absorb(input logic [15:0] c, input logic [7:0] b,
                                                 input logic [15:0] p);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
        return r;
    endfunction

    function automatic line_res_t make_line_byte(input logic [7:0] b, input logic c,
                                                 input logic s);
        line_res_t r;
        r.line_byte = b;
        r.last_out  = 1'b0;
        r.closing   = c;
        r.no_frame  = s;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Work out the line bytes one accepted request produces
    task automatic predict_line_bytes(input logic f, input logic [7:0] t, input logic [7:0] l,
                                      input logic [7:0] d);
        line_res_t   run[$];
        logic [15:0] inv;
        logic        close_tail;
        close_tail = 1'b0;
        if (f == FUNC_START)
        begin
            run.push_back(make_line_byte(FLAG_BYTE, 1'b0, STATUS_OK));
            run.push_back(make_line_byte(t, 1'b0, STATUS_OK));
            run.push_back(make_line_byte(l, 1'b0, STATUS_OK));
            if (l == 8'd0)
            begin
                crc_shadow  = CRC_INIT;
                left_shadow = 8'd0;
                open_shadow = 1'b0;
                close_tail  = 1'b1;
            end
            else
            begin
                crc_shadow  = crc16_absorb(crc16_absorb(CRC_INIT, t, poly_shadow), l, poly_shadow);
                left_shadow = l;
                open_shadow = 1'b1;
            end
        end
        else if (!open_shadow)
            run.push_back(make_line_byte(ERR_BYTE, 1'b0, STATUS_NO_FRAME));
        else
        begin
            crc_shadow = crc16_absorb(crc_shadow, d, poly_shadow);
            if (d == FLAG_BYTE || d == ESC_BYTE)
            begin
                run.push_back(make_line_byte(ESC_BYTE, 1'b0, STATUS_OK));
                run.push_back(make_line_byte(d ^ ESC_FLIP, 1'b0, STATUS_OK));
            end
            else
                run.push_back(make_line_byte(d, 1'b0, STATUS_OK));
            left_shadow = left_shadow - 8'd1;
            if (left_shadow == 8'd0)
            begin
                open_shadow = 1'b0;
                close_tail  = 1'b1;
            end
        end
        // CRC tail goes out unescaped, low byte first
        if (close_tail)
        begin
            inv = ~crc_shadow;
            run.push_back(make_line_byte(inv[7:0], 1'b0, STATUS_OK));
            run.push_back(make_line_byte(inv[15:8], 1'b0, STATUS_OK));
            run.push_back(make_line_byte(FLAG_BYTE, 1'b1, STATUS_OK));
        end
        run[run.size()-1].last_out = 1'b1;
        foreach (run[k])
            expected_bytes.push_back(run[k]);
    endtask

    // Request driver: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                predict_line_bytes(func, tag, length, data_byte);
                items_taken++;
            end
            if (!(item_valid && item_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_req = pending_items.pop_front();
                    item_valid <= 1'b1;
                    func       <= next_req.func;
                    tag        <= next_req.tag;
                    length     <= next_req.len;
                    data_byte  <= next_req.data;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = sender_gaps ? $urandom_range(0, 5) : 0;
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Line-side stall: replays an 8-bit pattern, reshuffled whenever stall_tick[5:0] wraps to zero
    always @(posedge clk)
    begin
        stall_tick = stall_tick + 16'd1;
        if (stall_tick[5:0] == 6'd0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_pat = 8'h00;
            else
                stall_pat = 8'($urandom_range(0, 255)) & ~(8'h01 << $urandom_range(0, 7));
        end
        line_stall <= stall_pat[stall_tick[2:0]];
    end

    // Line monitor: compare each accepted byte with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && line_valid && !line_stall)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("line byte %02h with nothing outstanding", out_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.line_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, want.line_byte));
                if (last_of_run !== want.last_out)
                    report_mismatch($sformatf("last_of_run %b, want %b (byte %02h)",
                                              last_of_run, want.last_out, want.line_byte));
                if (frame_end !== want.closing)
                    report_mismatch($sformatf("frame_end %b, want %b (byte %02h)",
                                              frame_end, want.closing, want.line_byte));
                if (status !== want.no_frame)
                    report_mismatch($sformatf("status %b, want %b", status, want.no_frame));
                bytes_checked++;
                if (want.closing)
                    frames_closed++;
                if (want.no_frame)
                    orphan_bytes++;
            end
        end
    end

    task automatic push_start(input logic [7:0] t, input logic [7:0] l);
        frame_req_t r;
        r.func = FUNC_START;
        r.tag  = t;
        r.len  = l;
        r.data = 8'($urandom_range(0, 255));
        pending_items.push_back(r);
        phase_items++;
    endtask

    task automatic push_data(input logic [7:0] d);
        frame_req_t r;
        r.func = FUNC_DATA;
        r.tag  = 8'($urandom_range(0, 255));
        r.len  = 8'($urandom_range(0, 255));
        r.data = d;
        pending_items.push_back(r);
        phase_items++;
    endtask

    // Payload bytes lean towards the two stuffed codes
    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_frame(input logic [7:0] t, input logic [7:0] l, input int n);
        push_start(t, l);
        repeat (n)
            push_data(pick_payload());
    endtask

    // Search a one-byte frame whose CRC tail byte hits a line code
    task automatic find_tail_frame(input logic hi_half, input logic [7:0] target,
                                   output logic [7:0] t_out, output logic [7:0] d_out,
                                   output logic hit);
        logic [15:0] c;
        int t;
        int d;
        hit   = 1'b0;
        t_out = 8'h00;
        d_out = 8'h00;
        for (t = 0; t < 256 && !hit; t++)
            for (d = 0; d < 256 && !hit; d++)
            begin
                c = ~crc16_absorb(crc16_absorb(crc16_absorb(CRC_INIT, 8'(t), poly_shadow),
                                               8'd1, poly_shadow), 8'(d), poly_shadow);
                if ((hi_half ? c[15:8] : c[7:0]) == target)
                begin
                    hit   = 1'b1;
                    t_out = 8'(t);
                    d_out = 8'(d);
                end
            end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0);
    endtask

    task automatic write_poly(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        crc_poly  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        poly_shadow = v;
        poly_writes++;
    endtask

    // Random traffic: mostly complete frames, some abandoned, some orphan bytes
    task automatic random_phase(input int quota);
        int pick;
        int l;
        int n;
        phase_items = 0;
        while (phase_items < quota)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
            begin
                l = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
                queue_frame(8'($urandom_range(0, 255)), 8'(l), l);
            end
            else if (pick < 16)
            begin
                l = $urandom_range(0, 255);
                n = (l == 0) ? 0 : $urandom_range(0, (l - 1 < 5) ? l - 1 : 5);
                queue_frame(8'($urandom_range(0, 255)), 8'(l), n);
            end
            else
                repeat ($urandom_range(1, 3))
                    push_data(pick_payload());
        end
    endtask

    // Safety net against a hung handshake
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        logic [15:0] poly_set[5];
        logic [7:0]  hit_tag;
        logic [7:0]  hit_data;
        logic        hit;
        poly_set = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)), 16'hA001, POLY_INIT};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: orphan byte, empty frame, extremes, stuffing, abandoned frame
        push_data(8'hFF);
        push_start(8'h00, 8'h00);
        push_start(8'hFF, 8'hFF);
        push_data(8'h00);
        push_data(8'hFF);
        push_start(FLAG_BYTE, 8'd3);
        push_data(FLAG_BYTE);
        push_data(ESC_BYTE);
        push_data(8'h00);
        push_data(FLAG_BYTE);
        push_start(ESC_BYTE, 8'd1);
        push_data(ESC_BYTE);
        push_start(8'h5A, 8'd2);
        push_data(8'h81);
        push_data(8'h24);
        // Tail bytes that look like line codes must stay unstuffed
        find_tail_frame(1'b0, FLAG_BYTE, hit_tag, hit_data, hit);
        if (hit)
        begin
            push_start(hit_tag, 8'd1);
            push_data(hit_data);
        end
        find_tail_frame(1'b1, ESC_BYTE, hit_tag, hit_data, hit);
        if (hit)
        begin
            push_start(hit_tag, 8'd1);
            push_data(hit_data);
        end
        wait_drained();

        // Random phases, one per polynomial; the third runs without sender gaps
        foreach (poly_set[p])
        begin
            write_poly(poly_set[p]);
            sender_gaps = (p != 2);
            random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d line bytes never arrived", expected_bytes.size()));

        $display("Sent %0d requests over %0d polynomial writes; checked %0d line bytes,",
                 items_taken, poly_writes, bytes_checked);
        $display("including %0d closed frames and %0d orphan payload bytes.",
                 frames_closed, orphan_bytes);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
sv/hdlc_pkg.sv
sv/hdlc_front.sv
sv/hdlc_queue.sv
sv/hdlc_back.sv
sv/hdlc_style_crc16_framer.sv
tb/tb.sv
